@@ sv/siv_pkg.sv @@
// shared constants for the sphere intersection volume unit
`default_nettype none
package siv_pkg;
  localparam logic [1:0] CASE_DISJOINT = 2'd0;
  localparam logic [1:0] CASE_INSIDE   = 2'd1;
  localparam logic [1:0] CASE_PARTIAL  = 2'd2;
  localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
  localparam logic [63:0] VOL_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
endpackage
`default_nettype wire

@@ sv/siv_sqrt.sv @@
// pipelined restoring square root, one result bit per stage
`default_nettype none
module siv_sqrt #(
  parameter int IN_W = 68,
  parameter int OUT_W = 34,
  parameter int TAG_W = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic             in_valid,
  input  wire logic [IN_W-1:0]  radicand,
  input  wire logic [TAG_W-1:0] in_tag,
  output logic                  out_valid,
  output logic [OUT_W-1:0]      root,
  output logic [TAG_W-1:0]      out_tag
);
  logic [OUT_W:0]     vld;
  logic [IN_W-1:0]    rad  [OUT_W+1];
  logic [OUT_W-1:0]   res  [OUT_W+1];
  logic [TAG_W-1:0]   tag  [OUT_W+1];

  assign vld[0] = in_valid;
  assign rad[0] = radicand;
  assign res[0] = '0;
  assign tag[0] = in_tag;

  for (genvar i = 0; i < OUT_W; i++) begin : g_stage
    localparam int B = OUT_W - 1 - i;
    logic [OUT_W-1:0] cand;
    logic [2*OUT_W-1:0] sq;
    assign cand = res[i] | (OUT_W'(1) << B);
    assign sq = {{OUT_W{1'b0}}, cand} * {{OUT_W{1'b0}}, cand};
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
      if (en) begin
        rad[i+1] <= rad[i];
        tag[i+1] <= tag[i];
        res[i+1] <= ((2*OUT_W)'(rad[i]) >= sq) ? cand : res[i];
      end
    end
  end

  assign out_valid = vld[OUT_W];
  assign root = res[OUT_W];
  assign out_tag = tag[OUT_W];
endmodule
`default_nettype wire

@@ sv/siv_div.sv @@
// pipelined restoring divider, one quotient bit per stage
`default_nettype none
module siv_div #(
  parameter int N_W = 64,
  parameter int D_W = 34,
  parameter int TAG_W = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic             in_valid,
  input  wire logic [N_W-1:0]   num,
  input  wire logic [D_W-1:0]   den,
  input  wire logic [TAG_W-1:0] in_tag,
  output logic                  out_valid,
  output logic [N_W-1:0]        quot,
  output logic [TAG_W-1:0]      out_tag
);
  logic [N_W:0]     vld;
  logic [N_W-1:0]   nm  [N_W+1];
  logic [D_W:0]     rm  [N_W+1];
  logic [D_W-1:0]   dn  [N_W+1];
  logic [TAG_W-1:0] tg  [N_W+1];

  assign vld[0] = in_valid;
  assign nm[0] = num;
  assign rm[0] = '0;
  assign dn[0] = den;
  assign tg[0] = in_tag;

  for (genvar i = 0; i < N_W; i++) begin : g_stage
    logic [D_W+1:0] sh;
    logic           ge;
    assign sh = {rm[i], nm[i][N_W-1]};
    assign ge = sh >= {2'b00, dn[i]};
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
      if (en) begin
        dn[i+1] <= dn[i];
        tg[i+1] <= tg[i];
        rm[i+1] <= ge ? (D_W+1)'(sh - {2'b00, dn[i]}) : (D_W+1)'(sh);
        nm[i+1] <= {nm[i][N_W-2:0], ge};
      end
    end
  end

  assign out_valid = vld[N_W];
  assign quot = nm[N_W];
  assign out_tag = tg[N_W];
endmodule
`default_nettype wire

@@ sv/siv_vol.sv @@
// pipelined pi*a*b*c/3 with 32-bit partial products, saturating to 64 bits
`default_nettype none
module siv_vol import siv_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        en,
  input  wire logic        in_valid,
  input  wire logic [63:0] a,
  input  wire logic [63:0] b,
  input  wire logic [63:0] c,
  output logic             out_valid,
  output logic [63:0]      vol,
  output logic             sat
);
  localparam int SHIFT = 60 + 2 * FRAC_BITS;
  // ceil(2^68/3): x*RECIP3 >> 68 is floor(x/3) for any x below 2^67
  localparam logic [66:0] RECIP3 = 67'h5_5555_5555_5555_5556;
  // a,b,c are below 2^36, product chains widen; keep full widths
  logic [8:0]   v;
  logic [127:0] ab;
  logic [63:0]  c1;
  logic [191:0] abc;
  logic [255:0] abcp;
  logic [63:0]  vo;
  logic         so;

  // stage 1: a*b as four 32x32 partials
  logic [63:0] p0, p1, p2, p3;
  logic [63:0] c0;
  always_ff @(posedge clk) begin
    if (en) begin
      p0 <= a[31:0] * b[31:0];
      p1 <= a[31:0] * b[63:32];
      p2 <= a[63:32] * b[31:0];
      p3 <= a[63:32] * b[63:32];
      c0 <= c;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      ab <= {64'd0, p0} + ({64'd0, p1} << 32) + ({64'd0, p2} << 32) + ({p3, 64'd0});
      c1 <= c0;
    end
  end
  // stage 3: ab (<=72 bits used) times c, split in 32-bit limbs
  logic [63:0] m0, m1, m2, m3, m4, m5;
  logic [63:0] pa0, pa1, pa2, pa3, pa4, pa5;
  logic [63:0] hi0, hi1;
  always_ff @(posedge clk) begin
    if (en) begin
      m0 <= ab[31:0] * c1[31:0];
      m1 <= ab[63:32] * c1[31:0];
      m2 <= ab[95:64] * c1[31:0];
      m3 <= ab[31:0] * c1[63:32];
      m4 <= ab[63:32] * c1[63:32];
      m5 <= ab[95:64] * c1[63:32];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      abc <= {128'd0, m0} + ({128'd0, m1} << 32) + ({128'd0, m2} << 64)
           + ({128'd0, m3} << 32) + ({128'd0, m4} << 64) + ({128'd0, m5} << 96);
    end
  end
  // stage 5: times pi, abc below 2^128
  always_ff @(posedge clk) begin
    if (en) begin
      pa0 <= abc[31:0] * PI_Q60[31:0];
      pa1 <= abc[63:32] * PI_Q60[31:0];
      pa2 <= abc[95:64] * PI_Q60[31:0];
      pa3 <= abc[127:96] * PI_Q60[31:0];
      pa4 <= abc[31:0] * PI_Q60[63:32];
      pa5 <= abc[63:32] * PI_Q60[63:32];
      hi0 <= abc[95:64] * PI_Q60[63:32];
      hi1 <= abc[127:96] * PI_Q60[63:32];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      abcp <= {192'd0, pa0} + ({192'd0, pa1} << 32) + ({192'd0, pa2} << 64)
            + ({192'd0, pa3} << 96) + ({192'd0, pa4} << 32) + ({192'd0, pa5} << 64)
            + ({192'd0, hi0} << 96) + ({192'd0, hi1} << 128);
    end
  end

  // stage 7: saturation test; below 3*2^64 the operand fits in 66 bits
  logic [255:0] xs;
  logic [65:0]  y;
  logic         big7, big8;
  logic [31:0]  yl [3];
  logic [31:0]  rl [3];
  logic [63:0]  dp [3][3];
  logic [191:0] prod;
  assign xs = abcp >> SHIFT;
  always_ff @(posedge clk) begin
    if (en) begin
      big7 <= xs >= (256'd3 << 64);
      y <= xs[65:0];
    end
  end
  // stage 8: divide by three as a reciprocal multiply, 32-bit limbs
  assign yl[0] = y[31:0];
  assign yl[1] = y[63:32];
  assign yl[2] = {30'd0, y[65:64]};
  assign rl[0] = RECIP3[31:0];
  assign rl[1] = RECIP3[63:32];
  assign rl[2] = {29'd0, RECIP3[66:64]};
  always_ff @(posedge clk) begin
    if (en) begin
      big8 <= big7;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          dp[i][j] <= yl[i] * rl[j];
        end
      end
    end
  end
  always_comb begin
    prod = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod = prod + ({128'd0, dp[i][j]} << (32 * (i + j)));
      end
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      so <= big8;
      vo <= big8 ? VOL_MAX : prod[131:68];
    end
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[7:0], in_valid};
    end
  end
  assign out_valid = v[8];
  assign vol = vo;
  assign sat = so;
endmodule
`default_nettype wire

@@ sv/sphere_intersection_volume_unit.sv @@
// Sphere pair intersection and union volume. A beat in carries two spheres
// (signed Q16.16 centers, unsigned Q15.16 radii); a beat out carries the
// overlap case, the common and the union volume (unsigned Q48.16, saturating)
// and a saturation flag. Fully pipelined: one pair may enter every cycle while
// the output is not stalled. A result passes through the squared distance, 34
// square root stages (one per root bit), the classification and cap numerators,
// 128 divider stages (one per quotient bit of the cap height), a clamp register,
// the volume multipliers and the output register. The whole pipeline advances
// only while the output register is empty or being taken, so a stall at the
// output holds everything without loss, and s_tready is low only while a result
// waits unaccepted.
`default_nettype none
module sphere_intersection_volume_unit import siv_pkg::*; #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS = 16
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // first_center_x, first_center_y, first_center_z, first_radius,
  // second_center_x, second_center_y, second_center_z, second_radius
  input  wire logic [((8*COORD_WIDTH-2+7)/8)*8-1:0] s_tdata,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // overlap_case, intersect_volume, union_volume, saturated
  output logic [135:0]      m_tdata
);
  localparam int CW = COORD_WIDTH;
  localparam int RW = CW - 1;
  localparam int D2W = 2 * CW + 4;
  localparam int DW = CW + 2;
  localparam int VL = 9;
  localparam int TW = 2 * RW;

  logic en;
  logic [CW-1:0] ax, ay, az, bx, by, bz;
  logic [RW-1:0] r1, r2;
  assign ax = s_tdata[0*CW +: CW];
  assign ay = s_tdata[1*CW +: CW];
  assign az = s_tdata[2*CW +: CW];
  assign r1 = s_tdata[3*CW +: RW];
  assign bx = s_tdata[3*CW+RW +: CW];
  assign by = s_tdata[4*CW+RW +: CW];
  assign bz = s_tdata[5*CW+RW +: CW];
  assign r2 = s_tdata[6*CW+RW +: RW];

  // stage a: differences; stage b: squared distance
  logic          va, vb;
  logic [CW:0]   dx, dy, dz;
  logic [RW-1:0] r1a, r2a, r1b, r2b;
  logic [D2W-1:0] d2;
  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
    end else if (en) begin
      va <= s_tvalid;
      vb <= va;
    end
    if (en) begin
      dx <= $signed({bx[CW-1], bx}) - $signed({ax[CW-1], ax});
      dy <= $signed({by[CW-1], by}) - $signed({ay[CW-1], ay});
      dz <= $signed({bz[CW-1], bz}) - $signed({az[CW-1], az});
      r1a <= r1;
      r2a <= r2;
      d2 <= D2W'($signed(dx) * $signed(dx)) + D2W'($signed(dy) * $signed(dy))
          + D2W'($signed(dz) * $signed(dz));
      r1b <= r1a;
      r2b <= r2a;
    end
  end

  logic vs;
  logic [DW-1:0] dq;
  logic [TW-1:0] rt;
  siv_sqrt #(.IN_W(D2W), .OUT_W(DW), .TAG_W(TW)) u_sqrt (
    .clk(clk), .rst(rst), .en(en), .in_valid(vb), .radicand(d2),
    .in_tag({r2b, r1b}), .out_valid(vs), .root(dq), .out_tag(rt)
  );

  // stage c: classify and form cap numerators
  logic          vc, vd;
  logic [1:0]    kc;
  logic [RW-1:0] r1c, r2c;
  logic [DW:0]   sc, a1c, a2c, dd;
  logic [127:0]  n1, n2;
  logic [DW:0]   dd2;
  logic [1:0]    kd;
  logic [RW-1:0] r1d, r2d;
  logic [RW-1:0] r1t, r2t;
  always_comb begin
    r1c = rt[RW-1:0];
    r2c = rt[TW-1:RW];
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
      vd <= 1'b0;
    end else if (en) begin
      vc <= vs;
      vd <= vc;
    end
    if (en) begin
      if ({1'b0, dq} > (DW+1)'(r1c) + (DW+1)'(r2c)) begin
        kc <= CASE_DISJOINT;
      end else if ((DW+1)'(dq) <= ((r1c > r2c) ? (DW+1)'(r1c - r2c) : (DW+1)'(r2c - r1c))) begin
        kc <= CASE_INSIDE;
      end else begin
        kc <= CASE_PARTIAL;
      end
      sc <= (DW+1)'(r1c) + (DW+1)'(r2c) - (DW+1)'(dq);
      a1c <= (DW+1)'(r2c) + (DW+1)'(dq) - (DW+1)'(r1c);
      a2c <= (DW+1)'(r1c) + (DW+1)'(dq) - (DW+1)'(r2c);
      dd <= {dq, 1'b0};
      r1t <= r1c;
      r2t <= r2c;
      n1 <= 128'(sc) * 128'(a1c);
      n2 <= 128'(sc) * 128'(a2c);
      dd2 <= dd;
      kd <= kc;
      r1d <= r1t;
      r2d <= r2t;
    end
  end

  localparam int T2 = 2 + 2 * RW;
  logic vq1, vq2;
  logic [127:0] h1, h2;
  logic [T2-1:0] tq;
  logic [T2-1:0] tq2;
  siv_div #(.N_W(128), .D_W(DW+1), .TAG_W(T2)) u_div1 (
    .clk(clk), .rst(rst), .en(en), .in_valid(vd), .num(n1), .den(dd2),
    .in_tag({kd, r2d, r1d}), .out_valid(vq1), .quot(h1), .out_tag(tq)
  );
  siv_div #(.N_W(128), .D_W(DW+1), .TAG_W(T2)) u_div2 (
    .clk(clk), .rst(rst), .en(en), .in_valid(vd), .num(n2), .den(dd2),
    .in_tag({kd, r2d, r1d}), .out_valid(vq2), .quot(h2), .out_tag(tq2)
  );

  // stage e: clamp heights, feed four volume units
  logic [RW-1:0] r1e, r2e;
  logic [1:0]    ke;
  logic [63:0]   hc1, hc2, tr1, tr2;
  logic          ve;
  assign r1e = tq[RW-1:0];
  assign r2e = tq[2*RW-1:RW];
  assign ke = tq[T2-1:2*RW];
  always_comb begin
    tr1 = 64'(r1e) << 1;
    tr2 = 64'(r2e) << 1;
    hc1 = (h1 > 128'(tr1)) ? tr1 : h1[63:0];
    hc2 = (h2 > 128'(tr2)) ? tr2 : h2[63:0];
  end
  logic [63:0] hf1, hf2, rf1, rf2;
  logic [1:0]  kf;
  always_ff @(posedge clk) begin
    if (rst) begin
      ve <= 1'b0;
    end else if (en) begin
      ve <= vq1 & vq2;
    end
    if (en) begin
      hf1 <= hc1;
      hf2 <= hc2;
      rf1 <= 64'(r1e);
      rf2 <= 64'(r2e);
      kf <= ke;
    end
  end

  logic w1, w2, w3, w4;
  logic [63:0] v1, v2, c1, c2;
  logic s1, s2, s3, s4;
  siv_vol #(.FRAC_BITS(FRAC_BITS)) u_v1 (.clk(clk), .rst(rst), .en(en),
    .in_valid(ve), .a(rf1), .b(rf1), .c(rf1 << 2), .out_valid(w1), .vol(v1), .sat(s1));
  siv_vol #(.FRAC_BITS(FRAC_BITS)) u_v2 (.clk(clk), .rst(rst), .en(en),
    .in_valid(ve), .a(rf2), .b(rf2), .c(rf2 << 2), .out_valid(w2), .vol(v2), .sat(s2));
  siv_vol #(.FRAC_BITS(FRAC_BITS)) u_c1 (.clk(clk), .rst(rst), .en(en),
    .in_valid(ve), .a(hf1), .b(hf1), .c(3 * rf1 - hf1), .out_valid(w3), .vol(c1), .sat(s3));
  siv_vol #(.FRAC_BITS(FRAC_BITS)) u_c2 (.clk(clk), .rst(rst), .en(en),
    .in_valid(ve), .a(hf2), .b(hf2), .c(3 * rf2 - hf2), .out_valid(w4), .vol(c2), .sat(s4));

  logic [1:0] kp [VL];
  logic [RW-1:0] ra [VL], rb [VL];
  always_ff @(posedge clk) begin
    if (en) begin
      kp[0] <= kf;
      ra[0] <= rf1[RW-1:0];
      rb[0] <= rf2[RW-1:0];
      for (int i = 1; i < VL; i++) begin
        kp[i] <= kp[i-1];
        ra[i] <= ra[i-1];
        rb[i] <= rb[i-1];
      end
    end
  end

  // final combine into output register
  logic [1:0]  kg;
  logic [64:0] cs, ss;
  logic [63:0] inter, uni;
  logic        sat;
  always_comb begin
    kg = kp[VL-1];
    cs = {1'b0, c1} + {1'b0, c2};
    ss = {1'b0, v1} + {1'b0, v2};
    sat = s1 | s2;
    case (kg)
      CASE_DISJOINT: inter = '0;
      CASE_INSIDE:   inter = (rb[VL-1] > ra[VL-1]) ? v1 : v2;
      default: begin
        sat = sat | s3 | s4 | cs[64];
        inter = cs[64] ? VOL_MAX : cs[63:0];
      end
    endcase
    if (ss >= {1'b0, inter}) begin
      if (ss - {1'b0, inter} > {1'b0, VOL_MAX}) begin
        uni = VOL_MAX;
        sat = 1'b1;
      end else begin
        uni = ss[63:0] - inter;
      end
    end else begin
      uni = '0;
    end
  end

  logic ov;
  assign en = !ov || m_tready;
  assign s_tready = en;
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (en) begin
      ov <= w1;
    end
    if (en) begin
      m_tdata <= {5'd0, sat, uni, inter, kg};
    end
  end
  assign m_tvalid = ov;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata)) else $error("output moved in stall");
  a_lanes: assert property (@(posedge clk) disable iff (rst)
    w1 == w3) else $error("volume lanes out of step");
  a_div: assert property (@(posedge clk) disable iff (rst)
    vq1 |-> (vq2 && tq == tq2)) else $error("divider lanes out of step");
  a_case: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[1:0] != 2'd3) else $error("bad overlap case");
endmodule
`default_nettype wire

@@ tb/sphere_volume_checker.sv @@
// sphere volume checker: watches both streams, predicts each result and compares it
`timescale 1ns / 1ps
`default_nettype none
module sphere_volume_checker import siv_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  input  wire logic         s_tready,
  input  wire logic [255:0] s_tdata,
  input  wire logic         m_tvalid,
  input  wire logic         m_tready,
  input  wire logic [135:0] m_tdata,
  output int                fail_count,
  output int                waiting
);
  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] inter;
    logic [63:0] uni;
    logic        sat;
  } volume_result_t;

  volume_result_t volume_q[$];

  function automatic logic [65:0] axis_sq(logic [31:0] a, logic [31:0] b);
    logic signed [32:0] dx;
    logic [32:0] ad;
    dx = $signed({b[31], b}) - $signed({a[31], a});
    ad = dx[32] ? -dx : dx;
    return 66'(ad) * 66'(ad);
  endfunction

  function automatic logic [63:0] floor_sqrt(logic [67:0] v);
    logic [63:0] root;
    logic [63:0] cand;
    root = '0;
    for (int i = 63; i >= 0; i--) begin
      cand = root | (64'd1 << i);
      if (128'(cand) * 128'(cand) <= 128'(v)) root = cand;
    end
    return root;
  endfunction

  // x*y*z*pi / 3 with the q60 pi and two fraction scalings dropped
  function automatic logic [63:0] pi_vol(logic [63:0] x, logic [63:0] y, logic [63:0] z,
                                         inout logic sat);
    logic [255:0] p;
    p = 256'(x) * 256'(y) * 256'(z) * 256'(PI_Q60);
    p = (p >> 92) / 3;
    if (p[255:64] != 0) begin
      sat = 1'b1;
      return VOL_MAX;
    end
    return p[63:0];
  endfunction

  function automatic logic [63:0] cap_vol(logic [63:0] s, logic [63:0] a, logic [63:0] two_d,
                                          logic [63:0] r, inout logic sat);
    logic [127:0] q;
    logic [63:0] h;
    q = (128'(s) * 128'(a)) / 128'(two_d);
    h = q[63:0];
    if (h > 2 * r) h = 2 * r;
    return pi_vol(h, h, 3 * r - h, sat);
  endfunction

  function automatic volume_result_t predict_volumes(logic [255:0] d);
    volume_result_t res;
    logic [63:0] r1, r2, center_dist, rdiff, v1, v2, c1, c2, s, sum;
    logic [67:0] d2;
    r1 = 64'(d[126:96]);
    r2 = 64'(d[253:223]);
    d2 = 68'(axis_sq(d[31:0], d[158:127])) + 68'(axis_sq(d[63:32], d[190:159]))
       + 68'(axis_sq(d[95:64], d[222:191]));
    center_dist = floor_sqrt(d2);
    rdiff = r1 > r2 ? r1 - r2 : r2 - r1;
    res.sat = 1'b0;
    v1 = pi_vol(r1, r1, 4 * r1, res.sat);
    v2 = pi_vol(r2, r2, 4 * r2, res.sat);
    if (center_dist > r1 + r2) begin
      res.kind = CASE_DISJOINT;
      res.inter = '0;
    end else if (center_dist <= rdiff) begin
      res.kind = CASE_INSIDE;
      res.inter = r2 > r1 ? v1 : v2;
    end else begin
      res.kind = CASE_PARTIAL;
      s = r1 + r2 - center_dist;
      c1 = cap_vol(s, r2 + center_dist - r1, 2 * center_dist, r1, res.sat);
      c2 = cap_vol(s, r1 + center_dist - r2, 2 * center_dist, r2, res.sat);
      res.inter = c1 + c2;
      if (res.inter < c1) begin
        res.inter = VOL_MAX;
        res.sat = 1'b1;
      end
    end
    sum = v1 + v2;
    if (sum < v1) begin
      if (sum >= res.inter) begin
        res.uni = VOL_MAX;
        res.sat = 1'b1;
      end else begin
        res.uni = sum - res.inter;
      end
    end else begin
      res.uni = sum >= res.inter ? sum - res.inter : '0;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    volume_result_t want;
    int errs;
    errs = 0;
    if (rst) begin
      fail_count <= 0;
      waiting <= 0;
    end else begin
      if (s_tvalid && s_tready) volume_q.push_back(predict_volumes(s_tdata));
      if (m_tvalid && m_tready) begin
        if (volume_q.size() == 0) begin
          $error("result beat with nothing pending: %h", m_tdata);
          errs++;
        end else begin
          want = volume_q.pop_front();
          if (m_tdata[1:0] !== want.kind) begin
            $error("overlap_case expected %0d actual %0d", want.kind, m_tdata[1:0]);
            errs++;
          end
          if (m_tdata[65:2] !== want.inter) begin
            $error("intersect_volume expected %h actual %h", want.inter, m_tdata[65:2]);
            errs++;
          end
          if (m_tdata[129:66] !== want.uni) begin
            $error("union_volume expected %h actual %h", want.uni, m_tdata[129:66]);
            errs++;
          end
          if (m_tdata[130] !== want.sat) begin
            $error("saturated expected %0d actual %0d", want.sat, m_tdata[130]);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
      waiting <= volume_q.size();
    end
  end
endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
// top of the sphere intersection volume testbench: stimulus, stalls and verdict
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  localparam int RANDOM_PAIRS = 1030;
  localparam int QUIET_TAIL = 120;
  localparam int IDLE_LIMIT = 20000;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [255:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [135:0] m_tdata;
  logic         quiet = 1'b0;
  int           fail_count;
  int           waiting;
  int           idle_cycles = 0;
  int           stall_left = 0;

  always #10 clk = ~clk;

  sphere_intersection_volume_unit u_dut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata
  );

  sphere_volume_checker u_checker (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata,
    .fail_count, .waiting
  );

  // receiver stalls in bursts, none once the quiet tail starts
  always @(posedge clk) begin
    if (rst || quiet) begin
      m_tready <= !rst;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      m_tready <= 1'b0;
      stall_left <= $urandom_range(0, 7);
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic logic [255:0] pack_pair(
    logic [31:0] x1, logic [31:0] y1, logic [31:0] z1, logic [30:0] r1,
    logic [31:0] x2, logic [31:0] y2, logic [31:0] z2, logic [30:0] r2);
    return {2'b00, r2, z2, y2, x2, r1, z1, y1, x1};
  endfunction

  task automatic send_pair(logic [255:0] beat);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= beat;
    do @(posedge clk); while (!s_tready);
  endtask

  // two spheres of random scale placed close enough that all cases occur
  task automatic send_near_pair();
    logic [30:0] r1, r2;
    logic [31:0] c1 [3];
    logic [31:0] c2 [3];
    int unsigned sc, reach;
    sc = $urandom_range(2, 29);
    r1 = 31'($urandom_range(0, (1 << sc) - 1));
    r2 = $urandom_range(0, 3) == 0 ? r1 : 31'($urandom_range(0, (1 << sc) - 1));
    reach = (r1 + r2) / 2 + 1;
    for (int a = 0; a < 3; a++) begin
      c1[a] = $urandom_range(0, 1 << 30) - (1 << 29);
      c2[a] = c1[a] + $urandom_range(0, 2 * reach) - reach;
    end
    send_pair(pack_pair(c1[0], c1[1], c1[2], r1, c2[0], c2[1], c2[2], r2));
  endtask

  initial begin
    logic [30:0] rmax;
    logic [31:0] cmin, cmax;
    rmax = '1;
    cmin = 32'h8000_0000;
    cmax = 32'h7FFF_FFFF;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    // all zero: two points at the same place
    send_pair(pack_pair(0, 0, 0, 0, 0, 0, 0, 0));
    // concentric equal spheres
    send_pair(pack_pair(5, 6, 7, 31'h10000, 5, 6, 7, 31'h10000));
    // largest radii concentric and at opposite corners (the disjoint union saturates), then zero radii far apart
    send_pair(pack_pair(0, 0, 0, rmax, 0, 0, 0, rmax));
    send_pair(pack_pair(cmin, cmin, cmin, rmax, cmax, cmax, cmax, rmax));
    send_pair(pack_pair(cmax, cmin, cmax, 0, cmin, cmax, cmin, 0));
    // first inside second, second inside first
    send_pair(pack_pair(0, 0, 0, 31'h10000, 32'h8000, 0, 0, 31'h30000));
    send_pair(pack_pair(0, 0, 0, 31'h30000, 0, 32'h8000, 0, 31'h10000));
    // zero radius inside a sphere
    send_pair(pack_pair(0, 0, 0, 0, 32'h100, 0, 0, 31'h20000));
    // disjoint and exactly touching from outside
    send_pair(pack_pair(0, 0, 0, 31'h10000, 32'h50000, 0, 0, 31'h10000));
    send_pair(pack_pair(0, 0, 0, 31'h10000, 32'h20000, 0, 0, 31'h10000));
    // touching from inside and a one-lsb partial overlap
    send_pair(pack_pair(0, 0, 0, 31'h20000, 32'h10000, 0, 0, 31'h10000));
    send_pair(pack_pair(0, 0, 0, 31'h20000, 32'h10001, 0, 0, 31'h10000));
    send_pair(pack_pair(0, 0, 0, 1, 1, 0, 0, 1));
    // partial overlaps, small and large
    send_pair(pack_pair(0, 0, 0, 31'h10000, 32'h10000, 0, 0, 31'h10000));
    send_pair(pack_pair(cmin, 0, 0, 31'h4000_0000, cmin + 32'h4000_0000, 32'h1000, 0,
                        31'h4000_0000));
    send_pair(pack_pair(0, 0, 0, rmax, cmax, 0, 0, rmax));
    send_pair(pack_pair(32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000, 31'h18000,
                        32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 31'h28000));
    for (int n = 0; n < RANDOM_PAIRS; n++) begin
      if (n == RANDOM_PAIRS - QUIET_TAIL) quiet = 1'b1;
      if ($urandom_range(0, 4) == 0)
        send_pair(pack_pair($urandom, $urandom, $urandom, 31'($urandom),
                            $urandom, $urandom, $urandom, 31'($urandom)));
      else send_near_pair();
    end
    s_tvalid <= 1'b0;
    while (waiting != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
`default_nettype wire
